>>> hw/rtl/png_stored_image_encoder_assert.svh
// Assertion macros used by the checker file.
`ifndef PNG_STORED_IMAGE_ENCODER_ASSERT_SVH
`define PNG_STORED_IMAGE_ENCODER_ASSERT_SVH

// Holds in the same cycle.
`define PSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Holds in the following cycle.
`define PSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/pngenc_pkg.sv
package pngenc_pkg;

    localparam logic [13:0] MAX_WIDTH        = 14'd8192;
    localparam logic [13:0] MAX_HEIGHT       = 14'd8192;
    localparam logic [15:0] STORED_BLOCK_MAX = 16'd65535;
    localparam logic [16:0] ADLER_MOD        = 17'd65521;
    localparam logic [31:0] CRC_POLY         = 32'hedb88320;
    localparam logic [31:0] CRC_INIT         = 32'hffffffff;
    localparam int          QUEUE_DEPTH      = 4;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [5:0] HEAD_LAST = 6'd42;
    localparam logic [5:0] BLK_LAST  = 6'd4;
    localparam logic [5:0] TAIL_LAST = 6'd19;

    typedef enum logic [2:0] {
        BS_NEXT,
        BS_HEAD,
        BS_BLK,
        BS_FILT,
        BS_PIX,
        BS_TAIL
    } t_bst;

    typedef struct packed {
        logic frame_start;
        logic row_start;
        logic frame_end;
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] pixel_byte;
    } t_item;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/pngenc_front.sv
module pngenc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_space,
    input  logic [14:0]       i_row_bytes,
    input  logic [13:0]       i_rows,
    output logic              o_push,
    output pngenc_pkg::t_item o_item,
    output logic              o_busy
);

    logic        r_phase, n_phase;
    logic [14:0] r_rbc, n_rbc;
    logic [12:0] r_rc, n_rc;
    logic        row_end;
    logic        frame_end;

    assign o_ready = i_space;
    assign o_push  = i_valid && i_space;
    assign o_busy  = r_phase;

    always_comb begin
        row_end   = ({1'b0, r_rbc} + 16'd1) >= {1'b0, i_row_bytes};
        frame_end = row_end && (({1'b0, r_rc} + 14'd1) >= i_rows);
        o_item.pixel_byte      = i_byte;
        o_item.cls.frame_start = !r_phase;
        o_item.cls.row_start   = (r_rbc == 15'd0);
        o_item.cls.frame_end   = frame_end;
        n_phase = r_phase;
        n_rbc   = r_rbc;
        n_rc    = r_rc;
        if (o_push) begin
            n_phase = !frame_end;
            n_rbc   = row_end ? 15'd0 : r_rbc + 15'd1;
            if (row_end) begin
                n_rc = frame_end ? 13'd0 : r_rc + 13'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_rbc   <= '0;
            r_rc    <= '0;
        end else begin
            r_phase <= n_phase;
            r_rbc   <= n_rbc;
            r_rc    <= n_rc;
        end
    end

endmodule

>>> hw/rtl/pngenc_fifo.sv
module pngenc_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pngenc_pkg::t_item i_data,
    output logic              o_space,
    input  logic              i_pop,
    output logic              o_valid,
    output pngenc_pkg::t_item o_data
);

    localparam int AW = $clog2(pngenc_pkg::QUEUE_DEPTH);

    pngenc_pkg::t_item r_mem [pngenc_pkg::QUEUE_DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [AW:0]       r_cnt;
    logic              do_pop;

    assign o_space = (r_cnt != AW'(0) + (AW+1)'(pngenc_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push && o_space) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push && o_space) begin
                r_wp <= r_wp + AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push && o_space) - (AW+1)'(do_pop);
        end
    end

endmodule

>>> hw/rtl/pngenc_back.sv
module pngenc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pngenc_pkg::t_item i_item,
    output logic              o_pop,
    input  logic [13:0]       i_width,
    input  logic [13:0]       i_height,
    input  logic [27:0]       i_raw,
    input  logic [31:0]       i_idat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_byte,
    output logic              o_last,
    output logic              o_done
);

    pngenc_pkg::t_bst r_st, n_st, start_st, cur_st;
    logic [5:0]  r_idx, n_idx;
    logic        r_filt_done;
    logic [31:0] r_crc;
    logic [15:0] r_adl, r_adh, r_blk;
    logic [27:0] r_raw;
    logic        r_ovalid, r_olast, r_odone;
    logic [7:0]  r_obyte;

    logic        adv, fire;
    logic [7:0]  byte_v;
    logic        in_crc, crc_rst, is_raw, last_v, done_v;
    logic [31:0] w32, h32, crc_out, adler;
    logic [15:0] bsize, nbsize;
    logic        bfinal;
    logic [16:0] sum_l, sum_h;
    logic [15:0] nadl, nadh;

    assign adv     = !r_ovalid || i_ready;
    assign o_valid = r_ovalid;
    assign o_byte  = r_obyte;
    assign o_last  = r_olast;
    assign o_done  = r_odone;

    always_comb begin
        if (i_item.cls.frame_start) begin
            start_st = pngenc_pkg::BS_HEAD;
        end else if (r_blk == 16'd0) begin
            start_st = pngenc_pkg::BS_BLK;
        end else if (i_item.cls.row_start) begin
            start_st = pngenc_pkg::BS_FILT;
        end else begin
            start_st = pngenc_pkg::BS_PIX;
        end
        if (r_st == pngenc_pkg::BS_NEXT) begin
            cur_st = i_valid ? start_st : pngenc_pkg::BS_NEXT;
        end else begin
            cur_st = r_st;
        end
        fire = adv && (cur_st != pngenc_pkg::BS_NEXT);
    end

    // Next state.
    always_comb begin
        n_st  = r_st;
        n_idx = r_idx;
        if (fire) begin
            n_st  = cur_st;
            n_idx = r_idx + 6'd1;
            unique case (cur_st)
                pngenc_pkg::BS_HEAD: begin
                    if (r_idx == pngenc_pkg::HEAD_LAST) begin
                        n_st  = pngenc_pkg::BS_BLK;
                        n_idx = '0;
                    end
                end
                pngenc_pkg::BS_BLK: begin
                    if (r_idx == pngenc_pkg::BLK_LAST) begin
                        n_st  = (i_item.cls.row_start && !r_filt_done) ?
                                pngenc_pkg::BS_FILT : pngenc_pkg::BS_PIX;
                        n_idx = '0;
                    end
                end
                pngenc_pkg::BS_FILT: begin
                    n_st  = (r_blk == 16'd1) ? pngenc_pkg::BS_BLK : pngenc_pkg::BS_PIX;
                    n_idx = '0;
                end
                pngenc_pkg::BS_PIX: begin
                    n_st  = i_item.cls.frame_end ? pngenc_pkg::BS_TAIL : pngenc_pkg::BS_NEXT;
                    n_idx = '0;
                end
                pngenc_pkg::BS_TAIL: begin
                    if (r_idx == pngenc_pkg::TAIL_LAST) begin
                        n_st  = pngenc_pkg::BS_NEXT;
                        n_idx = '0;
                    end
                end
                default: begin
                    n_st  = pngenc_pkg::BS_NEXT;
                    n_idx = '0;
                end
            endcase
        end
    end

    // Outputs and datapath.
    always_comb begin
        w32     = {18'd0, i_width};
        h32     = {18'd0, i_height};
        crc_out = ~r_crc;
        adler   = {r_adh, r_adl};
        bfinal  = (r_raw <= 28'(pngenc_pkg::STORED_BLOCK_MAX));
        bsize   = bfinal ? r_raw[15:0] : pngenc_pkg::STORED_BLOCK_MAX;
        nbsize  = ~bsize;
        byte_v  = 8'h00;
        in_crc  = 1'b0;
        crc_rst = 1'b0;
        is_raw  = 1'b0;
        last_v  = 1'b0;
        done_v  = 1'b0;
        unique case (cur_st)
            pngenc_pkg::BS_HEAD: begin
                unique case (r_idx)
                    6'd0:  byte_v = 8'h89;
                    6'd1:  byte_v = 8'h50;
                    6'd2:  byte_v = 8'h4e;
                    6'd3:  byte_v = 8'h47;
                    6'd4:  byte_v = 8'h0d;
                    6'd5:  byte_v = 8'h0a;
                    6'd6:  byte_v = 8'h1a;
                    6'd7:  byte_v = 8'h0a;
                    6'd11: byte_v = 8'd13;
                    6'd12: byte_v = 8'h49;
                    6'd13: byte_v = 8'h48;
                    6'd14: byte_v = 8'h44;
                    6'd15: byte_v = 8'h52;
                    6'd16: byte_v = w32[31:24];
                    6'd17: byte_v = w32[23:16];
                    6'd18: byte_v = w32[15:8];
                    6'd19: byte_v = w32[7:0];
                    6'd20: byte_v = h32[31:24];
                    6'd21: byte_v = h32[23:16];
                    6'd22: byte_v = h32[15:8];
                    6'd23: byte_v = h32[7:0];
                    6'd24: byte_v = 8'd8;
                    6'd25: byte_v = 8'd2;
                    6'd29: byte_v = crc_out[31:24];
                    6'd30: byte_v = crc_out[23:16];
                    6'd31: byte_v = crc_out[15:8];
                    6'd32: byte_v = crc_out[7:0];
                    6'd33: byte_v = i_idat[31:24];
                    6'd34: byte_v = i_idat[23:16];
                    6'd35: byte_v = i_idat[15:8];
                    6'd36: byte_v = i_idat[7:0];
                    6'd37: byte_v = 8'h49;
                    6'd38: byte_v = 8'h44;
                    6'd39: byte_v = 8'h41;
                    6'd40: byte_v = 8'h54;
                    6'd41: byte_v = 8'h78;
                    6'd42: byte_v = 8'h01;
                    default: byte_v = 8'h00;
                endcase
                in_crc  = (r_idx >= 6'd12 && r_idx <= 6'd28) || (r_idx >= 6'd37);
                crc_rst = (r_idx == 6'd12) || (r_idx == 6'd37);
            end
            pngenc_pkg::BS_BLK: begin
                unique case (r_idx)
                    6'd0:    byte_v = {7'd0, bfinal};
                    6'd1:    byte_v = bsize[7:0];
                    6'd2:    byte_v = bsize[15:8];
                    6'd3:    byte_v = nbsize[7:0];
                    default: byte_v = nbsize[15:8];
                endcase
                in_crc = 1'b1;
            end
            pngenc_pkg::BS_FILT: begin
                in_crc = 1'b1;
                is_raw = 1'b1;
            end
            pngenc_pkg::BS_PIX: begin
                byte_v = i_item.pixel_byte;
                in_crc = 1'b1;
                is_raw = 1'b1;
                last_v = !i_item.cls.frame_end;
            end
            pngenc_pkg::BS_TAIL: begin
                unique case (r_idx)
                    6'd0:  byte_v = adler[31:24];
                    6'd1:  byte_v = adler[23:16];
                    6'd2:  byte_v = adler[15:8];
                    6'd3:  byte_v = adler[7:0];
                    6'd4:  byte_v = crc_out[31:24];
                    6'd5:  byte_v = crc_out[23:16];
                    6'd6:  byte_v = crc_out[15:8];
                    6'd7:  byte_v = crc_out[7:0];
                    6'd12: byte_v = 8'h49;
                    6'd13: byte_v = 8'h45;
                    6'd14: byte_v = 8'h4e;
                    6'd15: byte_v = 8'h44;
                    6'd16: byte_v = crc_out[31:24];
                    6'd17: byte_v = crc_out[23:16];
                    6'd18: byte_v = crc_out[15:8];
                    6'd19: byte_v = crc_out[7:0];
                    default: byte_v = 8'h00;
                endcase
                in_crc  = (r_idx <= 6'd3) || (r_idx >= 6'd12 && r_idx <= 6'd15);
                crc_rst = (r_idx == 6'd12);
                last_v  = (r_idx == pngenc_pkg::TAIL_LAST);
                done_v  = last_v;
            end
            default: byte_v = 8'h00;
        endcase
        o_pop = fire && last_v;

        sum_l = {1'b0, r_adl} + {9'd0, byte_v};
        nadl  = (sum_l >= pngenc_pkg::ADLER_MOD) ? 16'(sum_l - pngenc_pkg::ADLER_MOD)
                                                 : sum_l[15:0];
        sum_h = {1'b0, r_adh} + {1'b0, nadl};
        nadh  = (sum_h >= pngenc_pkg::ADLER_MOD) ? 16'(sum_h - pngenc_pkg::ADLER_MOD)
                                                 : sum_h[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= pngenc_pkg::BS_NEXT;
            r_idx       <= '0;
            r_filt_done <= 1'b0;
            r_ovalid    <= 1'b0;
            r_blk       <= '0;
        end else begin
            r_st  <= n_st;
            r_idx <= n_idx;
            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (o_pop) begin
                r_filt_done <= 1'b0;
            end else if (fire && cur_st == pngenc_pkg::BS_FILT) begin
                r_filt_done <= 1'b1;
            end
            if (fire) begin
                if (cur_st == pngenc_pkg::BS_HEAD && r_idx == 6'd0) begin
                    r_blk <= '0;
                end else if (cur_st == pngenc_pkg::BS_BLK && r_idx == pngenc_pkg::BLK_LAST) begin
                    r_blk <= bsize;
                end else if (is_raw && r_blk != 16'd0) begin
                    r_blk <= r_blk - 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_obyte <= byte_v;
            r_olast <= last_v;
            r_odone <= done_v;
            if (in_crc) begin
                r_crc <= pngenc_pkg::crc_byte(crc_rst ? pngenc_pkg::CRC_INIT : r_crc, byte_v);
            end
            if (cur_st == pngenc_pkg::BS_HEAD && r_idx == 6'd0) begin
                r_adl <= 16'd1;
                r_adh <= 16'd0;
            end else if (is_raw) begin
                r_adl <= nadl;
                r_adh <= nadh;
            end
            if (cur_st == pngenc_pkg::BS_HEAD && r_idx == pngenc_pkg::HEAD_LAST) begin
                r_raw <= i_raw;
            end else if (is_raw && r_raw != 28'd0) begin
                r_raw <= r_raw - 28'd1;
            end
        end
    end

endmodule

>>> hw/rtl/png_stored_image_encoder.sv
// Channel   Direction  Contents
// s_t*      in         tdata[7:0] = pixel_byte
// m_t*      out        tdata[7:0] = out_byte, tlast = run_last, tuser = frame_done
// APB       in/out     image_width at 0x0, image_height at 0x4
//
// One output byte leaves per cycle while m_tready holds and the queue has items; an item
// yields its pixel byte plus a row's filter byte, five bytes for a stored block header,
// 43 bytes at frame start and 20 at frame end, all produced by the back end's byte sequencer.
// A four-entry queue lets the input side keep accepting while the output stalls.
// Reset is synchronous; no clearing pass is needed.
module png_stored_image_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] pixel_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,
    output logic        m_tuser,   // [0] frame_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [13:0] r_width, r_height;
    logic [13:0] w_eff, h_eff;
    logic [14:0] w3;
    logic [27:0] r_raw_tot;
    logic [13:0] r_blocks;
    logic [31:0] r_idat;
    logic [28:0] y;
    logic [16:0] rem;
    logic        busy;
    logic        space, push, pop, q_valid;
    pngenc_pkg::t_item push_item, head_item;

    assign pready = 1'b1;

    always_comb begin
        if (r_width == 14'd0) begin
            w_eff = 14'd1;
        end else if (r_width > pngenc_pkg::MAX_WIDTH) begin
            w_eff = pngenc_pkg::MAX_WIDTH;
        end else begin
            w_eff = r_width;
        end
        if (r_height == 14'd0) begin
            h_eff = 14'd1;
        end else if (r_height > pngenc_pkg::MAX_HEIGHT) begin
            h_eff = pngenc_pkg::MAX_HEIGHT;
        end else begin
            h_eff = r_height;
        end
        w3     = {w_eff, 1'b0} + {1'b0, w_eff};
        y      = {1'b0, r_raw_tot} + 29'(pngenc_pkg::STORED_BLOCK_MAX) - 29'd1;
        rem    = {1'b0, y[15:0]} + {4'd0, y[28:16]};
        prdata = (paddr[2] == pngenc_pkg::REG_IMAGE_HEIGHT) ? {18'd0, r_height}
                                                            : {18'd0, r_width};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 14'd1;
            r_height <= 14'd1;
        end else if (psel && penable && pwrite && !busy) begin
            if (paddr[2] == pngenc_pkg::REG_IMAGE_WIDTH) begin
                r_width <= pwdata[13:0];
            end else begin
                r_height <= pwdata[13:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raw_tot <= 28'(({1'b0, w3} + 16'd1) * h_eff);
        r_blocks  <= {1'b0, y[28:16]} + 14'(rem >= {1'b0, pngenc_pkg::STORED_BLOCK_MAX});
        r_idat    <= {4'd0, r_raw_tot} + {16'd0, r_blocks, 2'd0} + {18'd0, r_blocks} + 32'd6;
    end

    pngenc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_tvalid),
        .o_ready     (s_tready),
        .i_byte      (s_tdata),
        .i_space     (space),
        .i_row_bytes (w3),
        .i_rows      (h_eff),
        .o_push      (push),
        .o_item      (push_item),
        .o_busy      (busy)
    );

    pngenc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .o_space (space),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_item)
    );

    pngenc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (head_item),
        .o_pop    (pop),
        .i_width  (w_eff),
        .i_height (h_eff),
        .i_raw    (r_raw_tot),
        .i_idat   (r_idat),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_byte   (m_tdata),
        .o_last   (m_tlast),
        .o_done   (m_tuser)
    );

endmodule

>>> hw/rtl/pngenc_checker.sv
`include "png_stored_image_encoder_assert.svh"

module pngenc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // The end of a frame always closes the run of its item.
    `PSE_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n, m_tvalid && m_tuser, m_tlast)

    // The closing byte of the IEND chunk is the last byte of its fixed CRC.
    `PSE_ASSERT_NOW(a_done_byte, i_clk, i_rst_n, m_tvalid && m_tuser, m_tdata == 8'h82)

    `PSE_ASSERT_NOW(a_pready, i_clk, i_rst_n, psel, pready)

    `PSE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

endmodule

bind png_stored_image_encoder pngenc_checker u_pngenc_checker (.*);
